// ===== rtl/core/s2g_pkg.sv =====
package s2g_pkg;

    localparam int GRID_DIM     = 129;
    localparam int IDX_W        = $clog2(GRID_DIM);
    localparam int ANGLE_W      = 32;
    localparam int CFG_W        = 24;
    localparam int CELL_W       = 23;
    localparam int XY_W         = 58;
    localparam int N_W          = 60;
    localparam int DIV_W        = CELL_W + IDX_W + 1;
    localparam int NQ_W         = DIV_W + 1;
    localparam int Z_W          = 24;
    localparam int RED_W        = 33;
    localparam int STEP_W       = 5;
    localparam int CORDIC_ITERS = 20;
    localparam int RED_STEPS    = 10;

    localparam logic [29:0]      CORDIC_GAIN = 30'd652032874;
    localparam logic [RED_W-1:0] TWO_PI      = 33'd6588397;
    localparam logic [RED_W:0]   RED_OFFSET  = 34'd2147817422;
    localparam logic signed [Z_W:0] PI_Z      = 25'sd3294199;
    localparam logic signed [Z_W:0] TWO_PI_Z  = 25'sd6588397;
    localparam logic signed [Z_W:0] HALF_PI_Z = 25'sd1647099;

    localparam logic [2:0] REG_ANGLE_START = 3'd0;
    localparam logic [2:0] REG_ANGLE_STEP  = 3'd1;
    localparam logic [2:0] REG_GRID_ORIGIN = 3'd2;
    localparam logic [2:0] REG_CELL_SIZE   = 3'd3;
    localparam logic [2:0] REG_MAX_RANGE   = 3'd4;

    localparam logic [1:0] ST_MARKED  = 2'd0;
    localparam logic [1:0] ST_SKIPPED = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;

    typedef struct packed {
        logic              load;
        logic              red_step;
        logic              fix;
        logic              cordic_step;
        logic              post;
        logic              chk;
        logic              div_step;
        logic              finish;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic outside;
    } t_stat;

    function automatic logic [Z_W-1:0] atan_q20(input logic [STEP_W-1:0] i);
        logic [Z_W-1:0] v;
        unique case (i)
            5'd0:    v = 24'd823550;
            5'd1:    v = 24'd486170;
            5'd2:    v = 24'd256879;
            5'd3:    v = 24'd130396;
            5'd4:    v = 24'd65451;
            5'd5:    v = 24'd32757;
            5'd6:    v = 24'd16383;
            5'd7:    v = 24'd8192;
            5'd8:    v = 24'd4096;
            5'd9:    v = 24'd2048;
            5'd10:   v = 24'd1024;
            5'd11:   v = 24'd512;
            5'd12:   v = 24'd256;
            5'd13:   v = 24'd128;
            5'd14:   v = 24'd64;
            5'd15:   v = 24'd32;
            5'd16:   v = 24'd16;
            5'd17:   v = 24'd8;
            5'd18:   v = 24'd4;
            5'd19:   v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/scan_to_grid_cell.sv =====
// laser scan sample to occupancy grid cell: each range sample is rotated by the running
// beam angle (20-step cordic), offset by the grid origin and floored by the cell size;
// one transaction in gives one transaction out. a hit runs through a load, 10 angle
// reduction steps, a fold, 20 cordic iterations, an offset step, a check step, 8
// restoring division steps and an output step. a skipped sample goes from the first
// reduction step to the output step, a cell outside the grid from the first division
// step. the block takes one sample at a time; the result sits in an output register
// so the next sample is accepted while it waits, and a result that finds the register
// still full holds in the output step until it drains. config must be written while
// idle; the block does not enforce it. writing angle_start also restarts the scan
module scan_to_grid_cell
    import s2g_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // config write port
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    // sample input
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [23:0]      i_range_value,
    input  logic             i_last_sample,
    // cell output
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_cell_col,
    output logic [7:0]       o_cell_row,
    output logic [1:0]       o_status,
    output logic             o_end_of_scan
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer: walks reduction, cordic and division steps
    s2g_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // config registers, beam angle, arithmetic and output register
    s2g_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_range_value (i_range_value),
        .i_last_sample (i_last_sample),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_cell_col    (o_cell_col),
        .o_cell_row    (o_cell_row),
        .o_status      (o_status),
        .o_end_of_scan (o_end_of_scan)
    );

endmodule

// ===== rtl/core/s2g_ctrl.sv =====
module s2g_ctrl
    import s2g_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RED    = 3'd1;
    localparam logic [2:0] S_FIX    = 3'd2;
    localparam logic [2:0] S_CORDIC = 3'd3;
    localparam logic [2:0] S_POST   = 3'd4;
    localparam logic [2:0] S_CHK    = 3'd5;
    localparam logic [2:0] S_DIV    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_ready;
        o_cmd       = '0;
        o_cmd.step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = STEP_W'(RED_STEPS - 1);
                    n_state    = S_RED;
                end
            end
            S_RED: begin
                if (i_stat.skip) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.red_step = 1'b1;
                    n_step         = r_step - 1'b1;
                    if (r_step == '0) n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_step    = '0;
                n_state   = S_CORDIC;
            end
            S_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                n_step            = r_step + 1'b1;
                if (r_step == STEP_W'(CORDIC_ITERS - 1)) n_state = S_POST;
            end
            S_POST: begin
                o_cmd.post = 1'b1;
                n_state    = S_CHK;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_step    = STEP_W'(IDX_W - 1);
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (i_stat.outside) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_step         = r_step - 1'b1;
                    if (r_step == '0) n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/core/s2g_datapath.sv =====
module s2g_datapath
    import s2g_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic [23:0]      i_range_value,
    input  logic             i_last_sample,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    output logic [7:0]       o_cell_col,
    output logic [7:0]       o_cell_row,
    output logic [1:0]       o_status,
    output logic             o_end_of_scan
);

    logic [CFG_W-1:0]  r_angle_start, r_angle_step, r_grid_origin, r_max_range;
    logic [CELL_W-1:0] r_cell_size;
    logic [ANGLE_W-1:0] r_beam;

    logic [RED_W-1:0]      r_red;
    logic signed [Z_W-1:0] r_z;
    logic                  r_flip;
    logic signed [XY_W-1:0] r_x, r_y;
    logic signed [NQ_W-1:0] r_nx, r_ny;
    logic [DIV_W-1:0]      r_rx, r_ry;
    logic [IDX_W-1:0]      r_qx, r_qy;
    logic                  r_skip, r_outside, r_last;

    logic [CELL_W-1:0] cell_eff;
    logic [DIV_W-1:0]  limit;
    logic [RED_W-1:0]  red_sub;
    logic signed [Z_W:0] z0, z1;
    logic signed [XY_W-1:0] xf, yf;
    logic signed [N_W-1:0]  org_q, dx, dy, sx, sy;
    logic [DIV_W-1:0] dsub;

    assign cell_eff = (r_cell_size == '0) ? CELL_W'(1) : r_cell_size;
    assign limit    = DIV_W'(GRID_DIM) * DIV_W'(cell_eff);
    assign red_sub  = TWO_PI << i_cmd.step;
    assign dsub     = DIV_W'(cell_eff) << i_cmd.step;

    // reduced angle into [-pi, pi], then folded into the right half plane
    always_comb begin
        z0 = $signed({2'b00, r_red[22:0]});
        if (z0 > PI_Z) z0 = z0 - TWO_PI_Z;
        z1 = z0;
        if (z0 > HALF_PI_Z)       z1 = z0 - PI_Z;
        else if (z0 < -HALF_PI_Z) z1 = z0 + PI_Z;
    end

    always_comb begin
        xf    = r_flip ? -r_x : r_x;
        yf    = r_flip ? -r_y : r_y;
        org_q = N_W'($signed(r_grid_origin)) <<< 30;
        dx    = N_W'(xf) - org_q;
        dy    = N_W'(yf) - org_q;
        sx    = dx >>> 30;
        sy    = dy >>> 30;
    end

    assign o_stat.skip    = r_skip;
    assign o_stat.outside = r_outside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_start <= '0;
            r_angle_step  <= '0;
            r_grid_origin <= 24'hFB0000;
            r_cell_size   <= 23'd5120;
            r_max_range   <= 24'd327680;
            r_beam        <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ANGLE_START: begin
                    r_angle_start <= i_cfg_data;
                    r_beam        <= ANGLE_W'($signed(i_cfg_data));
                end
                REG_ANGLE_STEP:  r_angle_step  <= i_cfg_data;
                REG_GRID_ORIGIN: r_grid_origin <= i_cfg_data;
                REG_CELL_SIZE:   r_cell_size   <= i_cfg_data[CELL_W-1:0];
                REG_MAX_RANGE:   r_max_range   <= i_cfg_data;
                default: ;
            endcase
        end else if (i_cmd.load) begin
            r_beam <= i_last_sample ? ANGLE_W'($signed(r_angle_start))
                                    : r_beam + ANGLE_W'($signed(r_angle_step));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            // offset by a multiple of 2pi so the angle is positive
            r_red  <= RED_W'((RED_W+1)'($signed(r_beam)) + RED_OFFSET);
            r_x    <= XY_W'(i_range_value * CORDIC_GAIN);
            r_y    <= '0;
            r_skip <= (i_range_value == '0) || (i_range_value > r_max_range);
            r_last <= i_last_sample;
            r_outside <= 1'b0;
            r_qx   <= '0;
            r_qy   <= '0;
        end
        if (i_cmd.red_step && r_red >= red_sub) r_red <= r_red - red_sub;
        if (i_cmd.fix) begin
            r_z    <= Z_W'(z1);
            r_flip <= (z0 > HALF_PI_Z) || (z0 < -HALF_PI_Z);
        end
        if (i_cmd.cordic_step) begin
            if (r_z >= 0) begin
                r_x <= r_x - (r_y >>> i_cmd.step);
                r_y <= r_y + (r_x >>> i_cmd.step);
                r_z <= r_z - $signed(atan_q20(i_cmd.step));
            end else begin
                r_x <= r_x + (r_y >>> i_cmd.step);
                r_y <= r_y - (r_x >>> i_cmd.step);
                r_z <= r_z + $signed(atan_q20(i_cmd.step));
            end
        end
        if (i_cmd.post) begin
            r_nx <= sx[NQ_W-1:0];
            r_ny <= sy[NQ_W-1:0];
        end
        if (i_cmd.chk) begin
            r_outside <= r_nx[NQ_W-1] || r_ny[NQ_W-1]
                      || (r_nx[DIV_W-1:0] >= limit) || (r_ny[DIV_W-1:0] >= limit);
            r_rx <= r_nx[DIV_W-1:0];
            r_ry <= r_ny[DIV_W-1:0];
        end
        if (i_cmd.div_step) begin
            if (r_rx >= dsub) r_rx <= r_rx - dsub;
            if (r_ry >= dsub) r_ry <= r_ry - dsub;
            r_qx <= {r_qx[IDX_W-2:0], r_rx >= dsub};
            r_qy <= {r_qy[IDX_W-2:0], r_ry >= dsub};
        end
        if (i_cmd.finish) begin
            o_end_of_scan <= r_last;
            if (r_skip) begin
                o_status   <= ST_SKIPPED;
                o_cell_col <= '0;
                o_cell_row <= '0;
            end else if (r_outside) begin
                o_status   <= ST_OUTSIDE;
                o_cell_col <= '0;
                o_cell_row <= '0;
            end else begin
                o_status   <= ST_MARKED;
                o_cell_col <= 8'(r_qx);
                o_cell_row <= 8'(r_qy);
            end
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

// checks scan_to_grid_cell against a cycle-free model of the beam geometry:
// every accepted range sample is projected here on the fly (angle wrap,
// quadrant fold, 20-step cordic, floor division by the cell size) and the
// expected grid cell is queued; each output transaction is compared with the
// oldest queued cell
module testbench;
    import s2g_pkg::*;

    localparam int    HALF_PERIOD = 2;
    localparam int    CYCLE_LIMIT = 1000000;
    localparam int    DRAIN_WAIT  = 60;       // longer than a hit takes
    localparam int    IDLE_PCT    = 9;
    localparam longint GAIN_Q30   = 64'sd652032874;
    localparam longint PI_Q20     = 64'sd3294199;
    localparam longint TWO_PI_Q20 = 64'sd6588397;
    localparam longint HPI_Q20    = 64'sd1647099;
    localparam longint ONE_Q30    = 64'sd1073741824;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [7:0] col;
        logic [7:0] row;
        logic [1:0] status;
        logic       eos;
    } grid_hit_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [2:0]       i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    logic [23:0]      i_range_value = '0;
    logic             i_last_sample = 1'b0;
    logic             o_valid;
    logic             i_ready = 1'b1;
    logic [7:0]       o_cell_col;
    logic [7:0]       o_cell_row;
    logic [1:0]       o_status;
    logic             o_end_of_scan;

    // model copy of the register file and the running beam angle
    logic [23:0] m_start  = 24'd0;
    logic [23:0] m_step   = 24'd0;
    logic [23:0] m_origin = 24'hFB0000;
    logic [22:0] m_cell   = 23'd5120;
    logic [23:0] m_max    = 24'd327680;
    logic [31:0] m_angle  = 32'd0;

    grid_hit_t expected_cells[$];
    int        n_errors = 0;
    int        n_samples = 0;
    int        n_results = 0;
    int        n_marked = 0;
    int        n_skipped = 0;
    int        n_outside = 0;
    int        n_cycles = 0;
    bit        calm = 1'b0;  // no idling on either side while set

    longint atan_tab [0:19] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192, 4096, 2048,
        1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
    };

    scan_to_grid_cell i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_range_value (i_range_value),
        .i_last_sample (i_last_sample),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_cell_col    (o_cell_col),
        .o_cell_row    (o_cell_row),
        .o_status      (o_status),
        .o_end_of_scan (o_end_of_scan)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d cells still expected", n_cycles,
                     expected_cells.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    // floor division, both operands in the same fixed point
    function automatic longint floor_quot(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    // projects one range sample onto the grid and advances the beam angle
    function automatic grid_hit_t project_sample(logic [23:0] rng, logic last);
        grid_hit_t res;
        longint    r, x, y, nx, ny, org, csz, c, w, rl;
        bit        flip;
        res = '{col: 8'd0, row: 8'd0, status: ST_SKIPPED, eos: last};
        if (rng != 0 && rng <= m_max) begin
            r = $signed(m_angle);
            r = r % TWO_PI_Q20;
            if (r < 0)
                r = r + TWO_PI_Q20;
            if (r > PI_Q20)
                r = r - TWO_PI_Q20;
            // fold into the right half plane, negate the vector afterwards
            flip = 1'b0;
            if (r > HPI_Q20) begin
                r = r - PI_Q20;
                flip = 1'b1;
            end else if (r < -HPI_Q20) begin
                r = r + PI_Q20;
                flip = 1'b1;
            end
            rl = rng;
            x = rl * GAIN_Q30;
            y = 0;
            for (int i = 0; i < 20; i++) begin
                if (r >= 0) begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    r  = r - atan_tab[i];
                end else begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    r  = r + atan_tab[i];
                end
                x = nx;
                y = ny;
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            org = $signed(m_origin);
            org = org * ONE_Q30;
            csz = (m_cell == 0) ? 1 : m_cell;
            csz = csz * ONE_Q30;
            c = floor_quot(x - org, csz);
            w = floor_quot(y - org, csz);
            if (c < 0 || c >= GRID_DIM || w < 0 || w >= GRID_DIM) begin
                res.status = ST_OUTSIDE;
            end else begin
                res.status = ST_MARKED;
                res.col = c[7:0];
                res.row = w[7:0];
            end
        end
        if (last)
            m_angle = {{8{m_start[23]}}, m_start};
        else
            m_angle = m_angle + {{8{m_step[23]}}, m_step};
        return res;
    endfunction

    // result side: random backpressure and comparison against the queue
    always @(posedge i_clk) begin
        grid_hit_t got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{col: o_cell_col, row: o_cell_row, status: o_status, eos: o_end_of_scan};
            n_results++;
            if (expected_cells.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected transaction col %0d row %0d status %0d eos %0b",
                         $time, got.col, got.row, got.status, got.eos);
            end else begin
                want = expected_cells.pop_front();
                if (got.status == ST_MARKED) n_marked++;
                else if (got.status == ST_SKIPPED) n_skipped++;
                else n_outside++;
                if (got.col !== want.col) begin
                    n_errors++;
                    $display("%0t: col expected %0d actual %0d", $time, want.col, got.col);
                end
                if (got.row !== want.row) begin
                    n_errors++;
                    $display("%0t: row expected %0d actual %0d", $time, want.row, got.row);
                end
                if (got.status !== want.status) begin
                    n_errors++;
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             got.status);
                end
                if (got.eos !== want.eos) begin
                    n_errors++;
                    $display("%0t: end_of_scan expected %0b actual %0b", $time, want.eos,
                             got.eos);
                end
            end
        end
        i_ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // sends one sample; called at a rising edge, returns at the accepting edge
    // with valid still high, so the caller sends again or calls stop_input
    task automatic send_sample(logic [23:0] rng, logic last);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_range_value <= rng;
        i_last_sample <= last;
        do @(negedge i_clk); while (!o_ready);
        @(posedge i_clk);
        expected_cells = {expected_cells, project_sample(rng, last)};
        n_samples++;
    endtask

    task automatic stop_input();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // register writes only with the pipeline empty
    task automatic write_reg(logic [2:0] idx, logic [23:0] data);
        stop_input();
        while (expected_cells.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ANGLE_START: begin
                m_start = data;
                m_angle = {{8{data[23]}}, data};
            end
            REG_ANGLE_STEP:  m_step = data;
            REG_GRID_ORIGIN: m_origin = data;
            REG_CELL_SIZE:   m_cell = data[22:0];
            REG_MAX_RANGE:   m_max = data;
            default: ;
        endcase
    endtask

    task automatic set_all(logic [23:0] start, logic [23:0] stp, logic [23:0] org,
                           logic [23:0] csz, logic [23:0] mx);
        write_reg(REG_ANGLE_STEP, stp);
        write_reg(REG_GRID_ORIGIN, org);
        write_reg(REG_CELL_SIZE, csz);
        write_reg(REG_MAX_RANGE, mx);
        write_reg(REG_ANGLE_START, start);
    endtask

    // range mostly inside the accepted window, sometimes anything at all
    function automatic logic [23:0] pick_range();
        int p;
        p = $urandom_range(99);
        if (p < 5)
            return 24'd0;
        if (p < 12)
            return 24'($urandom());
        if (p < 15)
            return m_max;
        if (m_max == 0)
            return 24'($urandom());
        return 24'($urandom_range(m_max, 1));
    endfunction

    task automatic run_scans(int n_items);
        int left;
        left = 0;
        for (int k = 0; k < n_items; k++) begin
            if (left == 0)
                left = $urandom_range(40, 1);
            left--;
            send_sample(pick_range(), (left == 0) || (k == n_items - 1));
        end
    endtask

    // reset values: zero and too-far ranges, the max range edge, extremes
    task automatic test_reset_defaults();
        send_sample(24'd0, 1'b0);
        send_sample(24'd1, 1'b0);
        send_sample(24'd327680, 1'b0);           // exactly at max range
        send_sample(24'd327681, 1'b0);           // one step too far
        send_sample(24'hFFFFFF, 1'b0);
        send_sample(24'd65536, 1'b1);
        send_sample(24'd163840, 1'b0);
        send_sample(24'd5120, 1'b1);
    endtask

    // beam pointing backwards: negative offsets and cells below zero
    task automatic test_angle_folds();
        write_reg(REG_ANGLE_STEP, 24'd823550);   // about 45 degrees per beam
        write_reg(REG_ANGLE_START, 24'd3294199); // pi
        for (int k = 0; k < 8; k++)
            send_sample(k[0] ? 24'd327680 : 24'd196608, k == 7);
        write_reg(REG_ANGLE_START, 24'h800000);  // most negative start
        send_sample(24'd200000, 1'b0);
        send_sample(24'd1, 1'b1);
        write_reg(REG_ANGLE_START, 24'h7FFFFF);  // most positive start
        send_sample(24'd300000, 1'b0);
        send_sample(24'd327680, 1'b1);
        write_reg(REG_UNUSED, 24'hFFFFFF);       // must be ignored
        send_sample(24'd100000, 1'b1);
    endtask

    // register extremes, each setting followed by a few scans
    task automatic test_register_extremes();
        set_all(24'd0, 24'd6434, 24'h800000, 24'd0, 24'hFFFFFF);   // zero cell size
        run_scans(20);
        set_all(24'd0, 24'd6434, 24'd0, 24'd1, 24'hFFFFFF);        // smallest cell
        run_scans(20);
        set_all(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF);
        run_scans(20);
        set_all(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'hFFFFFF);
        run_scans(20);
        set_all(24'd0, 24'd0, 24'hFB0000, 24'd5120, 24'd0);        // every range too far
        run_scans(20);
        // one long scan at the largest step so the angle wraps past 2^31
        set_all(24'd0, 24'h7FFFFF, 24'h800000, 24'h400000, 24'hFFFFFF);
        calm = 1'b1;
        for (int k = 0; k < 300; k++)
            send_sample(pick_range(), k == 299);
        calm = 1'b0;
    endtask

    // random settings; mostly a grid that catches the beams
    task automatic test_random_scans();
        logic [23:0] csz, org, mx;
        for (int ph = 0; ph < 12; ph++) begin
            csz = (ph % 4 == 3) ? 24'($urandom_range(8388607, 0))
                                : 24'($urandom_range(20000, 500));
            mx  = (ph % 5 == 4) ? 24'($urandom()) : 24'(csz * $urandom_range(70, 20));
            org = (ph % 4 == 2) ? 24'($urandom()) : 24'(-(csz * $urandom_range(80, 40)));
            set_all(24'($urandom()), 24'($urandom_range(30000, 0) - 15000), org, csz, mx);
            calm = (ph == 5);
            run_scans(85);
            calm = 1'b0;
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_angle_folds();
        test_register_extremes();
        test_random_scans();
        stop_input();
        while (expected_cells.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("covered %0d samples, %0d results: %0d marked, %0d skipped, %0d outside",
                 n_samples, n_results, n_marked, n_skipped, n_outside);
        $display("register extremes, angle wrap and random scans done, %0d mismatches",
                 n_errors);
        if (n_errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
